[rtl/ppm_pkg.sv]
package ppm_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned NumW  = 32;
  localparam int unsigned MaxW  = 16;
  localparam int unsigned SmpW  = 16;
  localparam int unsigned KindW = 2;
  localparam int unsigned CodeW = 2;
  localparam int unsigned OutDataW = 104;

  localparam logic [ByteW-1:0] CH_3    = 8'h33;
  localparam logic [ByteW-1:0] CH_6    = 8'h36;
  localparam logic [ByteW-1:0] CH_HASH = 8'h23;
  localparam logic [ByteW-1:0] CH_SP   = 8'h20;
  localparam logic [ByteW-1:0] CH_TAB  = 8'h09;
  localparam logic [ByteW-1:0] CH_CR   = 8'h0D;
  localparam logic [ByteW-1:0] CH_LF   = 8'h0A;
  localparam logic [ByteW-1:0] CH_0    = 8'h30;
  localparam logic [ByteW-1:0] CH_9    = 8'h39;

  typedef enum logic [KindW-1:0] {
    KIND_HEADER = 2'd0,
    KIND_SAMPLE = 2'd1,
    KIND_ERROR  = 2'd2
  } kind_t;

  typedef enum logic [CodeW-1:0] {
    ERR_MAGIC   = 2'd0,
    ERR_NUMBER  = 2'd1,
    ERR_LARGE   = 2'd2,
    ERR_HDR_END = 2'd3
  } err_t;

  typedef struct packed {
    kind_t             kind;
    logic [NumW-1:0]   width;
    logic [NumW-1:0]   height;
    logic [MaxW-1:0]   max_value;
    logic              is_binary;
    logic [SmpW-1:0]   sample;
    err_t              code;
  } res_t;

endpackage

[rtl/ppm_parse_core.sv]
module ppm_parse_core (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       step,
  input  logic [ppm_pkg::ByteW-1:0]  data_byte,
  input  logic                       end_of_file,
  output logic                       res_valid,
  output ppm_pkg::res_t              res
);
  import ppm_pkg::*;

  typedef enum logic [3:0] {
    PH_MAGIC0  = 4'd0,
    PH_MAGIC1  = 4'd1,
    PH_WIDTH   = 4'd2,
    PH_HEIGHT  = 4'd3,
    PH_MAXVAL  = 4'd4,
    PH_SAMPLES = 4'd5,
    PH_P6BODY  = 4'd6,
    PH_HALT    = 4'd7
  } phase_t;

  phase_t            phase_r, phase_nxt;
  logic [NumW-1:0]   acc_r, acc_nxt;
  logic              seen_r, seen_nxt;
  logic              cmt_r, cmt_nxt;
  logic [NumW-1:0]   width_r, width_nxt;
  logic [NumW-1:0]   height_r, height_nxt;
  logic              bin_r, bin_nxt;

  logic              is_digit;
  logic              is_sep;
  logic              is_letter;
  logic [NumW+3:0]   acc_x10;
  logic              raise;
  err_t              raise_code;

  assign is_digit  = (data_byte >= CH_0) && (data_byte <= CH_9);
  assign is_sep    = data_byte inside {CH_SP, CH_TAB, CH_CR, CH_LF, CH_HASH};
  assign is_letter = data_byte inside {[8'h41:8'h5A], [8'h61:8'h7A]};
  assign acc_x10   = {1'b0, acc_r, 3'b000} + {3'b000, acc_r, 1'b0}
                     + {(NumW+4-ByteW)'(0), data_byte - CH_0};

  always_comb begin
    phase_nxt  = phase_r;
    acc_nxt    = acc_r;
    seen_nxt   = seen_r;
    cmt_nxt    = cmt_r;
    width_nxt  = width_r;
    height_nxt = height_r;
    bin_nxt    = bin_r;
    res_valid  = 1'b0;
    res        = '0;
    raise      = 1'b0;
    raise_code = ERR_MAGIC;

    case (phase_r)
      PH_MAGIC0: begin
        if (is_letter) begin
          phase_nxt = PH_MAGIC1;
        end else begin
          raise = 1'b1;
        end
      end
      PH_MAGIC1: begin
        if (data_byte == CH_3 || data_byte == CH_6) begin
          bin_nxt   = (data_byte == CH_6);
          phase_nxt = PH_WIDTH;
          acc_nxt   = '0;
          seen_nxt  = 1'b0;
          cmt_nxt   = 1'b0;
        end else begin
          raise = 1'b1;
        end
      end
      PH_WIDTH, PH_HEIGHT, PH_MAXVAL, PH_SAMPLES: begin
        if (cmt_r) begin
          if (data_byte == CH_LF) begin
            cmt_nxt = 1'b0;
          end
        end else if (is_digit) begin
          if (acc_x10[NumW+3:NumW] != '0) begin
            raise      = 1'b1;
            raise_code = ERR_LARGE;
          end else begin
            acc_nxt  = acc_x10[NumW-1:0];
            seen_nxt = 1'b1;
          end
        end else if (is_sep) begin
          if (data_byte == CH_HASH) begin
            cmt_nxt = 1'b1;
          end
          if (seen_r) begin
            acc_nxt  = '0;
            seen_nxt = 1'b0;
            case (phase_r)
              PH_WIDTH: begin
                width_nxt = acc_r;
                phase_nxt = PH_HEIGHT;
              end
              PH_HEIGHT: begin
                height_nxt = acc_r;
                phase_nxt  = PH_MAXVAL;
              end
              PH_MAXVAL: begin
                res_valid     = 1'b1;
                res.kind      = KIND_HEADER;
                res.width     = width_r;
                res.height    = height_r;
                res.max_value = acc_r[MaxW-1:0];
                res.is_binary = bin_r;
                phase_nxt     = bin_r ? PH_P6BODY : PH_SAMPLES;
              end
              default: begin
                res_valid  = 1'b1;
                res.kind   = KIND_SAMPLE;
                res.sample = acc_r[SmpW-1:0];
              end
            endcase
          end
        end else begin
          raise      = 1'b1;
          raise_code = (seen_r && phase_r == PH_MAXVAL) ? ERR_HDR_END : ERR_NUMBER;
        end
      end
      default: begin
      end
    endcase

    if (raise) begin
      phase_nxt = PH_HALT;
      acc_nxt   = '0;
      seen_nxt  = 1'b0;
      cmt_nxt   = 1'b0;
      res_valid = 1'b1;
      res       = '0;
      res.kind  = KIND_ERROR;
      res.code  = raise_code;
    end

    if (end_of_file) begin
      if (!res_valid) begin
        if (phase_nxt inside {PH_MAGIC0, PH_MAGIC1, PH_WIDTH, PH_HEIGHT, PH_MAXVAL}) begin
          res_valid = 1'b1;
          res       = '0;
          res.kind  = KIND_ERROR;
          res.code  = ERR_HDR_END;
        end else if (phase_nxt == PH_SAMPLES && seen_nxt) begin
          res_valid  = 1'b1;
          res        = '0;
          res.kind   = KIND_SAMPLE;
          res.sample = acc_nxt[SmpW-1:0];
        end
      end
      phase_nxt = PH_MAGIC0;
      acc_nxt   = '0;
      seen_nxt  = 1'b0;
      cmt_nxt   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_MAGIC0;
      acc_r    <= '0;
      seen_r   <= 1'b0;
      cmt_r    <= 1'b0;
      width_r  <= '0;
      height_r <= '0;
      bin_r    <= 1'b0;
    end else if (step) begin
      phase_r  <= phase_nxt;
      acc_r    <= acc_nxt;
      seen_r   <= seen_nxt;
      cmt_r    <= cmt_nxt;
      width_r  <= width_nxt;
      height_r <= height_nxt;
      bin_r    <= bin_nxt;
    end
  end

  a_eof_restart: assert property (@(posedge clk) disable iff (!rst_n)
    step && end_of_file |=> phase_r == PH_MAGIC0)
    else $error("parser did not restart after end of file");

  a_error_halts: assert property (@(posedge clk) disable iff (!rst_n)
    step && res_valid && res.kind == KIND_ERROR && !end_of_file |=> phase_r == PH_HALT)
    else $error("parser kept running after an error");

  a_header_phase: assert property (@(posedge clk) disable iff (!rst_n)
    step && res_valid && res.kind == KIND_HEADER |-> phase_r == PH_MAXVAL && seen_r)
    else $error("header emitted outside maximum value field");

  a_seen_phase: assert property (@(posedge clk) disable iff (!rst_n)
    seen_r |-> phase_r == PH_WIDTH || phase_r == PH_HEIGHT ||
               phase_r == PH_MAXVAL || phase_r == PH_SAMPLES)
    else $error("pending digits outside a number phase");

  a_cmt_phase: assert property (@(posedge clk) disable iff (!rst_n)
    cmt_r |-> !seen_r && (phase_r == PH_WIDTH || phase_r == PH_HEIGHT ||
               phase_r == PH_MAXVAL || phase_r == PH_SAMPLES || phase_r == PH_P6BODY))
    else $error("comment flag set outside a number phase");

endmodule

[rtl/ppm_header_and_ascii_sample_parser.sv]
// Channel | Dir | tdata                                         | tuser / tlast
// in_     | in  | [7:0] data_byte                               | tlast: end_of_file
// out_    | out | width, height, max, binary, sample, err code  | tuser[1:0]: result_kind
//
// One item per cycle sustained while out_tready holds; a byte passes the input register, then the result register.
// The decimal shift-add and phase update sit between the input and result registers.
// Synchronous active-low reset returns the parser to the magic first byte phase.
// A stalled result holds in the result register; the input register keeps taking
// items while the result register frees in the same cycle.
module ppm_header_and_ascii_sample_parser (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [ppm_pkg::ByteW-1:0]     in_tdata,   // [7:0] data_byte
  input  logic                          in_tlast,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [ppm_pkg::OutDataW-1:0]  out_tdata,  // [31:0] width_px, [63:32] height_px,
                                                    // [79:64] max_value, [80] is_binary_format,
                                                    // [96:81] sample_value, [98:97] error_code
  output logic [ppm_pkg::KindW-1:0]     out_tuser   // [1:0] result_kind
);
  import ppm_pkg::*;

  logic              s1_valid_r;
  logic [ByteW-1:0]  s1_byte_r;
  logic              s1_eof_r;
  logic              out_valid_r;
  res_t              out_res_r;
  logic              out_free;
  logic              s1_adv;
  logic              core_valid;
  res_t              core_res;

  assign out_free  = !out_valid_r || out_tready;
  assign s1_adv    = s1_valid_r && out_free;
  assign in_tready = !s1_valid_r || out_free;

  ppm_parse_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (s1_adv),
    .data_byte   (s1_byte_r),
    .end_of_file (s1_eof_r),
    .res_valid   (core_valid),
    .res         (core_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_r <= core_valid;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_byte_r <= in_tdata;
      s1_eof_r  <= in_tlast;
    end
    if (s1_adv && core_valid) begin
      out_res_r <= core_res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_res_r.kind;
  assign out_tdata  = {5'b00000, out_res_r.code, out_res_r.sample, out_res_r.is_binary,
                       out_res_r.max_value, out_res_r.height, out_res_r.width};

endmodule

[tb/tb.sv]
module tb;
  import ppm_pkg::*;

  localparam int QuietLimit  = 3000;
  localparam int StallCycles = 200;
  localparam int PrintCap    = 40;
  localparam err_t CodeIdle  = err_t'('0);

  typedef enum int {
    AT_LETTER  = 0,
    AT_KIND    = 1,
    AT_WIDTH   = 2,
    AT_HEIGHT  = 3,
    AT_MAXVAL  = 4,
    AT_SAMPLES = 5,
    AT_P6_BODY = 6,
    AT_HALTED  = 7
  } parse_phase_t;

  typedef struct {
    kind_t           kind;
    logic [NumW-1:0] width;
    logic [NumW-1:0] height;
    logic [MaxW-1:0] max_value;
    logic            is_binary;
    logic [SmpW-1:0] sample;
    err_t            code;
  } ppm_result_t;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                in_tvalid;
  logic                in_tready;
  logic [ByteW-1:0]    in_tdata;
  logic                in_tlast;
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [OutDataW-1:0] out_tdata;
  logic [KindW-1:0]    out_tuser;

  parse_phase_t    phase       = AT_LETTER;
  logic [NumW-1:0] number_acc  = '0;
  bit              have_digits = 1'b0;
  bit              in_remark   = 1'b0;
  logic [NumW-1:0] width_seen  = '0;
  logic [NumW-1:0] height_seen = '0;
  bit              p6_file     = 1'b0;

  ppm_result_t due_results[$];
  ppm_result_t oldest;
  logic [7:0]  file_bytes[$];

  int   tx_idle_pct;
  int   rx_idle_pct;
  bit   rx_hold      = 1'b0;
  int   fault_count  = 0;
  int   quiet_cycles = 0;
  event hold_kick;

  ppm_header_and_ascii_sample_parser dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic queue_result(input kind_t k, input logic [NumW-1:0] w, h,
                              input logic [MaxW-1:0] m, input logic bin,
                              input logic [SmpW-1:0] s, input err_t c);
    ppm_result_t r;
    r.kind      = k;
    r.width     = w;
    r.height    = h;
    r.max_value = m;
    r.is_binary = bin;
    r.sample    = s;
    r.code      = c;
    due_results.insert(due_results.size(), r);
  endtask

  task automatic halt_on_error(input err_t c);
    phase       = AT_HALTED;
    number_acc  = '0;
    have_digits = 1'b0;
    in_remark   = 1'b0;
    queue_result(KIND_ERROR, '0, '0, '0, 1'b0, '0, c);
  endtask

  task automatic take_number_byte(input logic [7:0] b, output bit made);
    logic [NumW+3:0] grown;
    logic [NumW-1:0] done;
    made = 1'b0;
    if (in_remark) begin
      if (b == CH_LF) in_remark = 1'b0;
    end else if (b >= CH_0 && b <= CH_9) begin
      grown = number_acc * 10 + (b - CH_0);
      if (grown > {4'b0, {NumW{1'b1}}}) begin
        halt_on_error(ERR_LARGE);
        made = 1'b1;
      end else begin
        number_acc  = grown[NumW-1:0];
        have_digits = 1'b1;
      end
    end else if (b == CH_SP || b == CH_TAB || b == CH_CR || b == CH_LF || b == CH_HASH) begin
      if (b == CH_HASH) in_remark = 1'b1;
      if (have_digits) begin
        done        = number_acc;
        number_acc  = '0;
        have_digits = 1'b0;
        case (phase)
          AT_WIDTH: begin
            width_seen = done;
            phase      = AT_HEIGHT;
          end
          AT_HEIGHT: begin
            height_seen = done;
            phase       = AT_MAXVAL;
          end
          AT_MAXVAL: begin
            queue_result(KIND_HEADER, width_seen, height_seen, done[MaxW-1:0], p6_file,
                         '0, CodeIdle);
            made  = 1'b1;
            phase = p6_file ? AT_P6_BODY : AT_SAMPLES;
          end
          default: begin
            queue_result(KIND_SAMPLE, '0, '0, '0, 1'b0, done[SmpW-1:0], CodeIdle);
            made = 1'b1;
          end
        endcase
      end
    end else if (have_digits && phase == AT_MAXVAL) begin
      halt_on_error(ERR_HDR_END);
      made = 1'b1;
    end else begin
      halt_on_error(ERR_NUMBER);
      made = 1'b1;
    end
  endtask

  task automatic parse_byte(input logic [7:0] b, input logic eof);
    bit made;
    made = 1'b0;
    case (phase)
      AT_LETTER: begin
        if ((b >= "A" && b <= "Z") || (b >= "a" && b <= "z")) begin
          phase = AT_KIND;
        end else begin
          halt_on_error(ERR_MAGIC);
          made = 1'b1;
        end
      end
      AT_KIND: begin
        if (b == CH_3 || b == CH_6) begin
          p6_file     = (b == CH_6);
          phase       = AT_WIDTH;
          number_acc  = '0;
          have_digits = 1'b0;
          in_remark   = 1'b0;
        end else begin
          halt_on_error(ERR_MAGIC);
          made = 1'b1;
        end
      end
      AT_WIDTH, AT_HEIGHT, AT_MAXVAL, AT_SAMPLES: take_number_byte(b, made);
      default: ;
    endcase
    if (eof) begin
      if (!made) begin
        if (phase <= AT_MAXVAL) begin
          halt_on_error(ERR_HDR_END);
        end else if (phase == AT_SAMPLES && have_digits) begin
          queue_result(KIND_SAMPLE, '0, '0, '0, 1'b0, number_acc[SmpW-1:0], CodeIdle);
        end
      end
      phase       = AT_LETTER;
      number_acc  = '0;
      have_digits = 1'b0;
      in_remark   = 1'b0;
    end
  endtask

  task automatic send_item(input logic [7:0] b, input logic last);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      in_tdata  <= 8'($urandom);
      in_tlast  <= 1'($urandom_range(1));
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    parse_byte(b, last);
  endtask

  task automatic send_text(input string s, input bit eof_last);
    for (int i = 0; i < s.len(); i++) send_item(s[i], eof_last && i == s.len() - 1);
  endtask

  task automatic send_file();
    for (int i = 0; i < file_bytes.size(); i++) send_item(file_bytes[i], i == file_bytes.size() - 1);
  endtask

  task automatic put_byte(input logic [7:0] b);
    file_bytes.insert(file_bytes.size(), b);
  endtask

  task automatic add_gap(input bit allow_empty);
    int         n;
    logic [7:0] c;
    n = $urandom_range(3, allow_empty ? 0 : 1);
    repeat (n) begin
      case ($urandom_range(5))
        0: put_byte(CH_TAB);
        1: put_byte(CH_CR);
        2: put_byte(CH_LF);
        3: begin
          put_byte(CH_HASH);
          repeat ($urandom_range(4)) begin
            c = 8'($urandom);
            if (c == CH_LF) c = CH_SP;
            put_byte(c);
          end
          put_byte(CH_LF);
        end
        default: put_byte(CH_SP);
      endcase
    end
  endtask

  task automatic add_number();
    longint unsigned v;
    logic [7:0]      digs[$];
    case ($urandom_range(39))
      0:       v = 64'd4294967296 + $urandom_range(99999);
      1:       v = 64'd4294967295 - $urandom_range(2);
      2, 3:    v = $urandom;
      4, 5:    v = $urandom_range(70000, 65530);
      default: v = $urandom_range(20);
    endcase
    if ($urandom_range(9) == 0) put_byte(CH_0);
    do begin
      digs.push_front(8'(CH_0 + v % 10));
      v = v / 10;
    end while (v != 0);
    foreach (digs[i]) put_byte(digs[i]);
  endtask

  task automatic build_file(input int max_samples, input bit stall_feed);
    bit is_p6;
    int n;
    file_bytes.delete();
    if ($urandom_range(1)) put_byte(8'(8'h41 + $urandom_range(25)));
    else put_byte(8'(8'h61 + $urandom_range(25)));
    is_p6 = !stall_feed && $urandom_range(3) == 0;
    put_byte(is_p6 ? CH_6 : CH_3);
    add_gap(1'b1);
    add_number();
    add_gap(1'b0);
    add_number();
    add_gap(1'b0);
    add_number();
    add_gap(1'b0);
    if (is_p6) begin
      repeat ($urandom_range(8)) put_byte(8'($urandom));
    end else begin
      n = stall_feed ? max_samples : $urandom_range(max_samples);
      for (int i = 0; i < n; i++) begin
        add_number();
        if (i < n - 1 || $urandom_range(1)) add_gap(1'b0);
      end
    end
    case (stall_feed ? 3 : $urandom_range(9))
      0: file_bytes[$urandom_range(file_bytes.size() - 1)] = 8'($urandom);
      1: begin
        n = $urandom_range(file_bytes.size(), 1);
        while (file_bytes.size() > n) void'(file_bytes.pop_back());
      end
      2: begin
        file_bytes.delete();
        repeat ($urandom_range(6, 1)) put_byte(8'($urandom));
      end
      default: ;
    endcase
  endtask

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    fault_count++;
    if (fault_count <= PrintCap)
      $display("%0t mismatch in %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
  endtask

  task automatic test_magic();
    send_item(8'hFF, 1'b1);
    send_text("Z7", 1'b0);
    send_item(8'h00, 1'b1);
  endtask

  task automatic test_header_forms();
    send_text("P61 2 3\t", 1'b0);
    send_item(8'h80, 1'b1);
    send_text("p3 1 1 9#\n5", 1'b1);
  endtask

  task automatic test_number_faults();
    send_text("P3 x", 1'b1);
    send_text("P31 1 2z", 1'b1);
    send_text("P3", 1'b1);
  endtask

  task automatic test_random_files(input int item_goal, input int max_samples);
    int sent;
    sent = 0;
    while (sent < item_goal) begin
      build_file(max_samples, 1'b0);
      sent += file_bytes.size();
      send_file();
    end
  endtask

  task automatic test_output_stall();
    -> hold_kick;
    repeat (2) begin
      build_file(10, 1'b1);
      send_file();
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (due_results.size() == 0) begin
        report_mismatch("result with none due", {out_tuser, out_tdata[61:0]}, '0);
      end else begin
        oldest = due_results.pop_front();
        if (out_tuser !== oldest.kind) report_mismatch("result_kind", out_tuser, oldest.kind);
        if (out_tdata[31:0] !== oldest.width)
          report_mismatch("width_px", out_tdata[31:0], oldest.width);
        if (out_tdata[63:32] !== oldest.height)
          report_mismatch("height_px", out_tdata[63:32], oldest.height);
        if (out_tdata[79:64] !== oldest.max_value)
          report_mismatch("max_value", out_tdata[79:64], oldest.max_value);
        if (out_tdata[80] !== oldest.is_binary)
          report_mismatch("is_binary_format", out_tdata[80], oldest.is_binary);
        if (out_tdata[96:81] !== oldest.sample)
          report_mismatch("sample_value", out_tdata[96:81], oldest.sample);
        if (out_tdata[98:97] !== oldest.code)
          report_mismatch("error_code", out_tdata[98:97], oldest.code);
        if (out_tdata[OutDataW-1:99] !== '0)
          report_mismatch("tdata padding", out_tdata[OutDataW-1:99], '0);
      end
    end
    out_tready <= !rx_hold && ($urandom_range(99) >= rx_idle_pct);
  end

  initial begin
    forever begin
      @(hold_kick);
      rx_hold <= 1'b1;
      repeat (StallCycles) @(posedge clk);
      rx_hold <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QuietLimit) begin
      $display("ppm_header_and_ascii_sample_parser test failed");
      $finish;
    end
  end

  initial begin
    rst_n       <= 1'b0;
    in_tvalid   <= 1'b0;
    in_tdata    <= '0;
    in_tlast    <= 1'b0;
    tx_idle_pct = 21;
    rx_idle_pct = 74;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    test_magic();
    test_header_forms();
    test_number_faults();
    test_random_files(110, 8);

    tx_idle_pct = 74;
    rx_idle_pct = 21;
    test_random_files(110, 8);

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    test_output_stall();
    test_random_files(100, 8);

    in_tvalid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fault_count == 0) begin
      $display("ppm_header_and_ascii_sample_parser test passed");
    end else begin
      $display("ppm_header_and_ascii_sample_parser test failed");
    end
    $finish;
  end

endmodule
